// File: src/hfe_pkg.sv
// Shared types, constants and helper functions of the Haar feature enumerator.
package hfe_pkg;

  localparam int COORD_BITS    = 6;
  localparam int EXT_BITS      = COORD_BITS + 2;
  localparam int SPLIT_BITS    = COORD_BITS + 1;
  localparam int KIND_BITS     = 2;
  localparam int KIND_EXT_BITS = KIND_BITS + 1;
  localparam int NUM_KINDS     = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int WINDOW_RESET  = 24;

  // x / 3 as (x * DIV3_MUL) >> DIV3_SHIFT, exact for every SPLIT_BITS-wide x
  localparam int DIV3_SHIFT    = SPLIT_BITS + 1;
  localparam int DIV3_MUL      = (2 ** DIV3_SHIFT + 2) / 3;
  localparam int DIV3_PROD     = SPLIT_BITS + DIV3_SHIFT;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [EXT_BITS-1:0]     ext_t;
  typedef logic [SPLIT_BITS-1:0]   split_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_HORIZ_TWO   = 2'd0,
    KIND_VERT_TWO    = 2'd1,
    KIND_HORIZ_THREE = 2'd2,
    KIND_VERT_THREE  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_WIDTH       = 3'd0,
    CFG_WINDOW_HEIGHT      = 3'd1,
    CFG_ENABLE_HORIZ_TWO   = 3'd2,
    CFG_ENABLE_VERT_TWO    = 3'd3,
    CFG_ENABLE_HORIZ_THREE = 3'd4,
    CFG_ENABLE_VERT_THREE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    coord_t                 width;
    coord_t                 height;
    logic [NUM_KINDS-1:0]   enable;
  } cfg_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } corner_t;

  typedef struct packed {
    logic    exhausted;
    logic    final_feature;
    kind_e   kind;
    corner_t pos;
  } feature_t;

  function automatic ext_t off_x(kind_e k);
    ext_t r;
    case (k)
      KIND_HORIZ_TWO:   r = ext_t'(1);
      KIND_HORIZ_THREE: r = ext_t'(2);
      default:          r = '0;
    endcase
    return r;
  endfunction

  function automatic ext_t off_y(kind_e k);
    ext_t r;
    case (k)
      KIND_VERT_TWO:   r = ext_t'(1);
      KIND_VERT_THREE: r = ext_t'(2);
      default:         r = '0;
    endcase
    return r;
  endfunction

  function automatic ext_t step_x(kind_e k);
    ext_t r;
    case (k)
      KIND_HORIZ_TWO:   r = ext_t'(2);
      KIND_HORIZ_THREE: r = ext_t'(3);
      default:          r = ext_t'(1);
    endcase
    return r;
  endfunction

  function automatic ext_t step_y(kind_e k);
    ext_t r;
    case (k)
      KIND_VERT_TWO:   r = ext_t'(2);
      KIND_VERT_THREE: r = ext_t'(3);
      default:         r = ext_t'(1);
    endcase
    return r;
  endfunction

  function automatic split_t div3(split_t x);
    logic [DIV3_PROD-1:0] prod;
    prod = DIV3_PROD'(x) * DIV3_PROD'(DIV3_MUL);
    return split_t'(prod >> DIV3_SHIFT);
  endfunction

endpackage

// File: src/hfe_if.sv
// Handshake channels of the Haar feature enumerator: configuration, request and feature.
interface hfe_cfg_if import hfe_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  coord_t   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface hfe_req_if import hfe_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, restart, input ready);
  modport sink (input valid, restart, output ready);
endinterface

interface hfe_feat_if import hfe_pkg::*; ();
  logic   valid;
  logic   ready;
  kind_e  feature_kind;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  coord_t split_first;
  coord_t split_second;
  logic   final_feature;
  logic   exhausted;

  modport source (
    output valid, feature_kind, start_x, start_y, end_x, end_y,
           split_first, split_second, final_feature, exhausted,
    input  ready
  );
  modport sink (
    input  valid, feature_kind, start_x, start_y, end_x, end_y,
           split_first, split_second, final_feature, exhausted,
    output ready
  );
endinterface

// File: src/hfe_cfg_regs.sv
// Configuration registers: window size and per-kind enables.
module hfe_cfg_regs import hfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hfe_cfg_if.sink   cfg,
  output cfg_t      cfg_o
);

  cfg_t cfg_d, cfg_q;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg.valid) begin
      case (cfg_idx_e'(cfg.index))
        CFG_WINDOW_WIDTH:       cfg_d.width     = cfg.data;
        CFG_WINDOW_HEIGHT:      cfg_d.height    = cfg.data;
        CFG_ENABLE_HORIZ_TWO:   cfg_d.enable[0] = cfg.data[0];
        CFG_ENABLE_VERT_TWO:    cfg_d.enable[1] = cfg.data[0];
        CFG_ENABLE_HORIZ_THREE: cfg_d.enable[2] = cfg.data[0];
        CFG_ENABLE_VERT_THREE:  cfg_d.enable[3] = cfg.data[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= coord_t'(WINDOW_RESET);
      cfg_q.height <= coord_t'(WINDOW_RESET);
      cfg_q.enable <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: src/hfe_step.sv
// Next-feature logic: advance within the held kind or open the next enabled kind.
module hfe_step import hfe_pkg::*; (
  input  cfg_t    cfg_i,
  input  logic    first_i,
  input  kind_e   kind_i,
  input  corner_t pos_i,
  output logic    ok_o,
  output kind_e   kind_o,
  output corner_t pos_o
);

  ext_t w, h, ax, ay, bx, by, ox, oy, sx, sy;
  ext_t by_step, bx_step, by_base, ay_inc, ay_row, ax_row, ax_col;
  logic in_win, hit_col, hit_row, hit_seek, hit_next, adv_ok;
  corner_t adv_pos, first_pos;
  logic [KIND_EXT_BITS-1:0] first_kind;
  logic [NUM_KINDS-1:0] cand;
  logic first_ok;
  kind_e first_sel;

  always_comb begin
    w  = ext_t'(cfg_i.width);
    h  = ext_t'(cfg_i.height);
    ax = ext_t'(pos_i.ax);
    ay = ext_t'(pos_i.ay);
    bx = ext_t'(pos_i.bx);
    by = ext_t'(pos_i.by);
    ox = off_x(kind_i);
    oy = off_y(kind_i);
    sx = step_x(kind_i);
    sy = step_y(kind_i);

    // next bottom-right corner for the same top-left corner
    in_win  = (bx < w) && (by < h);
    by_step = by + sy;
    bx_step = bx + sx;
    by_base = ay + oy;
    hit_col = in_win && (by_step < h);
    hit_row = in_win && (bx_step < w) && (by_base < h);

    // move the top-left corner on, then seek the first corner that fits
    ay_inc = ay + ext_t'(1);
    if (ay_inc >= h) begin
      ay_row = '0;
      ax_row = ax + ext_t'(1);
    end else begin
      ay_row = ay_inc;
      ax_row = ax;
    end
    ax_col   = ax_row + ext_t'(1);
    hit_seek = ((ax_row + ox) < w) && ((ay_row + oy) < h);
    hit_next = ((ax_row + ox) < w) && ((ax_col + ox) < w) && (oy < h);
    adv_ok   = hit_col || hit_row || hit_seek || hit_next;

    adv_pos = pos_i;
    if (hit_col) begin
      adv_pos.by = coord_t'(by_step);
    end else if (hit_row) begin
      adv_pos.bx = coord_t'(bx_step);
      adv_pos.by = coord_t'(by_base);
    end else if (hit_seek) begin
      adv_pos.ax = coord_t'(ax_row);
      adv_pos.ay = coord_t'(ay_row);
      adv_pos.bx = coord_t'(ax_row + ox);
      adv_pos.by = coord_t'(ay_row + oy);
    end else begin
      adv_pos.ax = coord_t'(ax_col);
      adv_pos.ay = '0;
      adv_pos.bx = coord_t'(ax_col + ox);
      adv_pos.by = coord_t'(oy);
    end

    // first feature of the lowest enabled kind at or after first_kind
    first_kind = first_i ? '0 : (KIND_EXT_BITS'(kind_i) + KIND_EXT_BITS'(1));
    for (int k = 0; k < NUM_KINDS; k++) begin
      cand[k] = cfg_i.enable[k] && (off_x(kind_e'(KIND_BITS'(k))) < w) &&
                (off_y(kind_e'(KIND_BITS'(k))) < h) &&
                (KIND_EXT_BITS'(k) >= first_kind);
    end
    first_ok  = |cand;
    first_sel = KIND_HORIZ_TWO;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if (cand[k]) first_sel = kind_e'(KIND_BITS'(k));
    end
    first_pos.ax = '0;
    first_pos.ay = '0;
    first_pos.bx = coord_t'(off_x(first_sel));
    first_pos.by = coord_t'(off_y(first_sel));

    if (!first_i && adv_ok) begin
      ok_o   = 1'b1;
      kind_o = kind_i;
      pos_o  = adv_pos;
    end else begin
      ok_o   = first_ok;
      kind_o = first_sel;
      pos_o  = first_pos;
    end
  end

endmodule

// File: src/hfe_split.sv
// Zone boundaries of a feature: midpoint for two-zone kinds, thirds for three-zone kinds.
module hfe_split import hfe_pkg::*; (
  input  feature_t feat_i,
  output coord_t   split_first_o,
  output coord_t   split_second_o
);

  split_t lo, hi, diff, sum;

  always_comb begin
    if (feat_i.kind inside {KIND_HORIZ_TWO, KIND_HORIZ_THREE}) begin
      lo = split_t'(feat_i.pos.ax);
      hi = split_t'(feat_i.pos.bx);
    end else begin
      lo = split_t'(feat_i.pos.ay);
      hi = split_t'(feat_i.pos.by);
    end
    diff = hi - lo;
    sum  = lo + hi;

    split_first_o  = '0;
    split_second_o = '0;
    if (!feat_i.exhausted) begin
      if (feat_i.kind inside {KIND_HORIZ_TWO, KIND_VERT_TWO}) begin
        split_first_o = coord_t'(sum >> 1);
      end else begin
        split_first_o  = coord_t'(lo + div3(diff));
        split_second_o = coord_t'(lo + div3(diff << 1));
      end
    end
  end

endmodule

// File: src/haar_feature_enumerator.sv
// Top level of the Haar feature enumerator: request register stage and result register stage.
//
// Each request on req hands out one Haar-like feature rectangle of the detection
// window on feat; restart=1 begins again from the first feature, restart=0 takes
// the next one. Kinds come horizontal two-zone, vertical two-zone, horizontal
// three-zone, vertical three-zone; disabled kinds are skipped. Once the list is
// used up every result carries exhausted=1 with all other fields zero, until a
// restart. final_feature marks the last feature before that.
// Window size and kind enables are written on cfg, one register per request,
// always ready; write them only while no request is in flight.
// The first stage computes the next feature and looks one feature ahead for
// final_feature, the second derives the zone boundaries.
// Throughput is one request per cycle; a stalled feat holds its result and the
// two stages keep taking requests until both are full, then req.ready drops.
// Reset restores a 24 x 24 window with all kinds enabled and starts from the
// first feature.
module haar_feature_enumerator import hfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hfe_cfg_if.sink    cfg,
  hfe_req_if.sink    req,
  hfe_feat_if.source feat
);

  cfg_t     cfg_cur;
  logic     out_en, s1_en, accept, restart, first, live;
  logic     step_ok, peek_ok;
  kind_e    step_kind, peek_kind;
  corner_t  step_pos, peek_pos;
  coord_t   split_first, split_second;

  kind_e    kind_d, kind_q;
  corner_t  pos_d, pos_q;
  logic     started_d, started_q, done_d, done_q;
  logic     s1_valid_d, s1_valid_q, out_valid_d, out_valid_q;
  feature_t s1_d, s1_q, out_q;
  coord_t   split_first_q, split_second_q;

  hfe_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg),
    .cfg_o  (cfg_cur)
  );

  hfe_step u_step (
    .cfg_i   (cfg_cur),
    .first_i (first),
    .kind_i  (kind_q),
    .pos_i   (pos_q),
    .ok_o    (step_ok),
    .kind_o  (step_kind),
    .pos_o   (step_pos)
  );

  // look one feature ahead to flag the last one
  hfe_step u_peek (
    .cfg_i   (cfg_cur),
    .first_i (1'b0),
    .kind_i  (step_kind),
    .pos_i   (step_pos),
    .ok_o    (peek_ok),
    .kind_o  (peek_kind),
    .pos_o   (peek_pos)
  );

  hfe_split u_split (
    .feat_i         (s1_q),
    .split_first_o  (split_first),
    .split_second_o (split_second)
  );

  assign out_en    = !out_valid_q || feat.ready;
  assign s1_en     = !s1_valid_q || out_en;
  assign req.ready = s1_en;
  assign accept    = req.valid && s1_en;
  assign restart   = req.restart;
  assign first     = !started_q || restart;
  assign live      = !(done_q && !restart) && step_ok;

  always_comb begin
    kind_d    = kind_q;
    pos_d     = pos_q;
    started_d = started_q;
    done_d    = done_q;
    if (accept && !(done_q && !restart)) begin
      started_d = 1'b1;
      if (step_ok) begin
        kind_d = step_kind;
        pos_d  = step_pos;
        done_d = 1'b0;
      end else begin
        done_d = 1'b1;
      end
    end

    s1_d = '0;
    if (live) begin
      s1_d.final_feature = !peek_ok;
      s1_d.kind          = step_kind;
      s1_d.pos           = step_pos;
    end else begin
      s1_d.exhausted = 1'b1;
    end

    s1_valid_d  = s1_en ? accept : s1_valid_q;
    out_valid_d = out_en ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_HORIZ_TWO;
      pos_q       <= '0;
      started_q   <= 1'b0;
      done_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      kind_q      <= kind_d;
      pos_q       <= pos_d;
      started_q   <= started_d;
      done_q      <= done_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (out_en && s1_valid_q) begin
      out_q          <= s1_q;
      split_first_q  <= split_first;
      split_second_q <= split_second;
    end
  end

  assign feat.valid         = out_valid_q;
  assign feat.feature_kind  = out_q.kind;
  assign feat.start_x       = out_q.pos.ax;
  assign feat.start_y       = out_q.pos.ay;
  assign feat.end_x         = out_q.pos.bx;
  assign feat.end_y         = out_q.pos.by;
  assign feat.split_first   = split_first_q;
  assign feat.split_second  = split_second_q;
  assign feat.final_feature = out_q.final_feature;
  assign feat.exhausted     = out_q.exhausted;

endmodule

// File: src/hfe_checker.sv
// Port-level checks of the Haar feature enumerator and their binding to the top level.
module hfe_checker import hfe_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   feat_valid_i,
  input logic   feat_ready_i,
  input kind_e  feature_kind_i,
  input coord_t start_x_i,
  input coord_t start_y_i,
  input coord_t end_x_i,
  input coord_t end_y_i,
  input coord_t split_first_i,
  input coord_t split_second_i,
  input logic   final_feature_i,
  input logic   exhausted_i
);

  logic is_horiz, is_two;

  assign is_horiz = (feature_kind_i == KIND_HORIZ_TWO) || (feature_kind_i == KIND_HORIZ_THREE);
  assign is_two   = (feature_kind_i == KIND_HORIZ_TWO) || (feature_kind_i == KIND_VERT_TWO);

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feat_valid_i && !feat_ready_i |=> feat_valid_i &&
      $stable({feature_kind_i, start_x_i, start_y_i, end_x_i, end_y_i,
               split_first_i, split_second_i, final_feature_i, exhausted_i}))
    else $error("feature result changed while stalled");

  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feat_valid_i && exhausted_i |-> !final_feature_i &&
      feature_kind_i == KIND_HORIZ_TWO && start_x_i == '0 && start_y_i == '0 &&
      end_x_i == '0 && end_y_i == '0 && split_first_i == '0 && split_second_i == '0)
    else $error("exhausted result carries nonzero fields");

  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feat_valid_i && !exhausted_i |-> end_x_i >= start_x_i && end_y_i >= start_y_i)
    else $error("bottom-right corner above or left of top-left corner");

  a_split_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feat_valid_i && !exhausted_i |->
      (is_horiz ? (split_first_i >= start_x_i && split_first_i <= end_x_i)
                : (split_first_i >= start_y_i && split_first_i <= end_y_i)) &&
      (is_two ? split_second_i == '0 : split_second_i >= split_first_i))
    else $error("zone boundary outside the feature rectangle");

endmodule

bind haar_feature_enumerator hfe_checker u_hfe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .feat_valid_i    (feat.valid),
  .feat_ready_i    (feat.ready),
  .feature_kind_i  (feat.feature_kind),
  .start_x_i       (feat.start_x),
  .start_y_i       (feat.start_y),
  .end_x_i         (feat.end_x),
  .end_y_i         (feat.end_y),
  .split_first_i   (feat.split_first),
  .split_second_i  (feat.split_second),
  .final_feature_i (feat.final_feature),
  .exhausted_i     (feat.exhausted)
);

// File: verif/haar_feature_enumerator_tb.sv
// Self-checking testbench for haar_feature_enumerator: paced requests, predictor, scoreboard.
module haar_feature_enumerator_tb;
  import hfe_pkg::*;

  localparam int       WATCHDOG_LIMIT = 3000;
  localparam int       HOLD_OFF_LEN   = 300;
  localparam int       DRAIN_CYCLES   = 10;
  localparam int       RANDOM_ITEMS   = 1075;
  localparam int       SHOWN_ERRORS   = 10;
  localparam cfg_idx_t CFG_UNUSED_A   = 3'd6;
  localparam cfg_idx_t CFG_UNUSED_B   = 3'd7;

  typedef struct {
    bit       is_cfg;
    cfg_idx_t idx;
    coord_t   data;
    bit       restart;
  } plan_item_t;

  typedef struct {
    kind_e  kind;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t split_a;
    coord_t split_b;
    logic   last;
    logic   exhausted;
  } feat_rec_t;

  typedef struct {
    int ax;
    int ay;
    int bx;
    int by;
  } rect_t;

  logic clk_i;
  logic rst_ni;

  hfe_cfg_if  cfg_ch ();
  hfe_req_if  req_ch ();
  hfe_feat_if feat_ch ();

  haar_feature_enumerator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch),
    .req    (req_ch),
    .feat   (feat_ch)
  );

  plan_item_t request_plan[$];
  feat_rec_t  pending_features[$];
  int         planned_requests;
  int         requests_taken;
  int         bad_results;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         stall_left;
  int         quiet_cycles;
  bit         long_stall;

  // predictor copy of the registers and the walk position
  int    win_w;
  int    win_h;
  bit    kind_on[NUM_KINDS];
  kind_e cur_kind;
  rect_t cur_rect;
  bit    walking;
  bit    used_up;

  function automatic int first_dx(kind_e k);
    case (k)
      KIND_HORIZ_TWO:   return 1;
      KIND_HORIZ_THREE: return 2;
      default:          return 0;
    endcase
  endfunction

  function automatic int first_dy(kind_e k);
    case (k)
      KIND_VERT_TWO:   return 1;
      KIND_VERT_THREE: return 2;
      default:         return 0;
    endcase
  endfunction

  function automatic int stride_x(kind_e k);
    case (k)
      KIND_HORIZ_TWO:   return 2;
      KIND_HORIZ_THREE: return 3;
      default:          return 1;
    endcase
  endfunction

  function automatic int stride_y(kind_e k);
    case (k)
      KIND_VERT_TWO:   return 2;
      KIND_VERT_THREE: return 3;
      default:         return 1;
    endcase
  endfunction

  // Move to the first top-left corner at or after (ax, ay) that still fits a feature.
  function automatic bit find_origin(kind_e k, inout rect_t r);
    while (r.ax < win_w) begin
      if (r.ax + first_dx(k) >= win_w) return 1'b0;
      if (r.ay + first_dy(k) < win_h) begin
        r.bx = r.ax + first_dx(k);
        r.by = r.ay + first_dy(k);
        return 1'b1;
      end
      r.ax++;
      r.ay = 0;
    end
    return 1'b0;
  endfunction

  function automatic bit step_within(kind_e k, inout rect_t r);
    if (r.bx < win_w && r.by < win_h) begin
      r.by += stride_y(k);
      if (r.by < win_h) return 1'b1;
      r.bx += stride_x(k);
      r.by = r.ay + first_dy(k);
      if (r.bx < win_w && r.by < win_h) return 1'b1;
    end
    r.ay++;
    if (r.ay >= win_h) begin
      r.ay = 0;
      r.ax++;
    end
    return find_origin(k, r);
  endfunction

  function automatic bit first_kind_from(int k0, inout kind_e k, inout rect_t r);
    for (int i = k0; i < NUM_KINDS; i++) begin
      if (kind_on[i]) begin
        r = '{0, 0, 0, 0};
        if (find_origin(kind_e'(i), r)) begin
          k = kind_e'(i);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic bit step_any(inout kind_e k, inout rect_t r);
    if (step_within(k, r)) return 1'b1;
    return first_kind_from(int'(k) + 1, k, r);
  endfunction

  function automatic feat_rec_t enumerate_next(bit restart);
    feat_rec_t f;
    rect_t     r;
    rect_t     ahead;
    kind_e     k;
    kind_e     ka;
    bit        found;
    int        s1;
    int        s2;
    f = '{KIND_HORIZ_TWO, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0};
    s1 = 0;
    s2 = 0;
    if (restart) begin
      walking = 1'b0;
      used_up = 1'b0;
    end
    if (used_up) begin
      f.exhausted = 1'b1;
      return f;
    end
    k = cur_kind;
    r = cur_rect;
    found = walking ? step_any(k, r) : first_kind_from(0, k, r);
    walking = 1'b1;
    if (!found) begin
      used_up = 1'b1;
      f.exhausted = 1'b1;
      return f;
    end
    cur_kind = k;
    cur_rect = r;
    case (k)
      KIND_HORIZ_TWO: s1 = (r.ax + r.bx) / 2;
      KIND_VERT_TWO:  s1 = (r.ay + r.by) / 2;
      KIND_HORIZ_THREE: begin
        s1 = r.ax + (r.bx - r.ax) / 3;
        s2 = r.ax + (2 * (r.bx - r.ax)) / 3;
      end
      default: begin
        s1 = r.ay + (r.by - r.ay) / 3;
        s2 = r.ay + (2 * (r.by - r.ay)) / 3;
      end
    endcase
    ahead = r;
    ka = k;
    f.kind    = k;
    f.sx      = coord_t'(r.ax);
    f.sy      = coord_t'(r.ay);
    f.ex      = coord_t'(r.bx);
    f.ey      = coord_t'(r.by);
    f.split_a = coord_t'(s1);
    f.split_b = coord_t'(s2);
    f.last    = !step_any(ka, ahead);
    return f;
  endfunction

  function automatic void apply_register(cfg_idx_t idx, coord_t data);
    case (idx)
      CFG_WINDOW_WIDTH:       win_w = int'(data);
      CFG_WINDOW_HEIGHT:      win_h = int'(data);
      CFG_ENABLE_HORIZ_TWO:   kind_on[KIND_HORIZ_TWO] = data[0];
      CFG_ENABLE_VERT_TWO:    kind_on[KIND_VERT_TWO] = data[0];
      CFG_ENABLE_HORIZ_THREE: kind_on[KIND_HORIZ_THREE] = data[0];
      CFG_ENABLE_VERT_THREE:  kind_on[KIND_VERT_THREE] = data[0];
      default: ;
    endcase
  endfunction

  task automatic check_feature(feat_rec_t want);
    if (want.kind !== feat_ch.feature_kind || want.sx !== feat_ch.start_x ||
        want.sy !== feat_ch.start_y || want.ex !== feat_ch.end_x ||
        want.ey !== feat_ch.end_y || want.split_a !== feat_ch.split_first ||
        want.split_b !== feat_ch.split_second || want.last !== feat_ch.final_feature ||
        want.exhausted !== feat_ch.exhausted) begin
      bad_results++;
      if (bad_results <= SHOWN_ERRORS) begin
        $display({"feature mismatch: exp kind=%0d a=(%0d,%0d) b=(%0d,%0d) ",
                  "split=%0d/%0d last=%0b exh=%0b"},
                 want.kind, want.sx, want.sy, want.ex, want.ey, want.split_a, want.split_b,
                 want.last, want.exhausted);
        $display({"                  got kind=%0d a=(%0d,%0d) b=(%0d,%0d) ",
                  "split=%0d/%0d last=%0b exh=%0b"},
                 feat_ch.feature_kind, feat_ch.start_x, feat_ch.start_y, feat_ch.end_x,
                 feat_ch.end_y, feat_ch.split_first, feat_ch.split_second,
                 feat_ch.final_feature, feat_ch.exhausted);
      end
    end
  endtask

  function automatic void push_cfg(cfg_idx_t idx, coord_t data);
    plan_item_t it;
    it = '{1'b1, idx, data, 1'b0};
    request_plan.insert(request_plan.size(), it);
  endfunction

  function automatic void push_req(bit restart);
    plan_item_t it;
    it = '{1'b0, CFG_WINDOW_WIDTH, '0, restart};
    request_plan.insert(request_plan.size(), it);
    planned_requests++;
  endfunction

  // Mostly tiny windows so that whole enumerations finish; now and then a large one.
  function automatic coord_t pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 70) return coord_t'($urandom_range(1, 4));
    if (r < 90) return coord_t'($urandom_range(5, 9));
    if ($urandom_range(1) == 0) return coord_t'(63);
    return coord_t'($urandom_range(10, 62));
  endfunction

  task automatic build_directed();
    // reset defaults: 24 x 24, all kinds
    push_req(1'b1);
    push_req(1'b0);
    push_req(1'b0);
    push_cfg(CFG_WINDOW_WIDTH, 6'd63);
    push_cfg(CFG_WINDOW_HEIGHT, 6'd63);
    push_req(1'b1);
    push_req(1'b0);
    push_req(1'b0);
    // writes past the last register must change nothing
    push_cfg(CFG_UNUSED_A, coord_t'($urandom));
    push_cfg(CFG_UNUSED_B, 6'h3f);
    push_req(1'b0);
    // zero width window
    push_cfg(CFG_WINDOW_WIDTH, 6'd0);
    push_req(1'b1);
    push_req(1'b0);
    // 2 x 2 window: run off the end, stay exhausted, then restart
    push_cfg(CFG_WINDOW_WIDTH, 6'd2);
    push_cfg(CFG_WINDOW_HEIGHT, 6'd2);
    push_req(1'b1);
    repeat (7) push_req(1'b0);
    push_req(1'b1);
    // nothing enabled
    push_cfg(CFG_ENABLE_HORIZ_TWO, 6'h3e);
    push_cfg(CFG_ENABLE_VERT_TWO, 6'd0);
    push_cfg(CFG_ENABLE_HORIZ_THREE, 6'd0);
    push_cfg(CFG_ENABLE_VERT_THREE, 6'd0);
    push_req(1'b1);
    // 3 x 3 window, vertical three-zone only
    push_cfg(CFG_WINDOW_WIDTH, 6'd3);
    push_cfg(CFG_WINDOW_HEIGHT, 6'd3);
    push_cfg(CFG_ENABLE_VERT_THREE, 6'h3f);
    push_req(1'b1);
    repeat (6) push_req(1'b0);
  endtask

  task automatic build_random();
    int len;
    while (planned_requests < RANDOM_ITEMS) begin
      for (int i = CFG_WINDOW_WIDTH; i <= CFG_ENABLE_VERT_THREE; i++) begin
        if ($urandom_range(99) < 40)
          push_cfg(cfg_idx_t'(i), (i <= CFG_WINDOW_HEIGHT) ? pick_dim() : coord_t'($urandom));
      end
      if ($urandom_range(99) < 5)
        push_cfg($urandom_range(1) ? CFG_UNUSED_A : CFG_UNUSED_B, coord_t'($urandom));
      len = $urandom_range(1, 60);
      // skipping the restart continues the held walk against the new bounds
      push_req($urandom_range(99) < 85);
      repeat (len - 1) push_req($urandom_range(99) < 2);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // request and register driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid   <= 1'b0;
      req_ch.restart <= 1'b0;
      cfg_ch.valid   <= 1'b0;
      cfg_ch.index   <= CFG_WINDOW_WIDTH;
      cfg_ch.data    <= '0;
    end else if (!(req_ch.valid && !req_ch.ready) && !(cfg_ch.valid && !cfg_ch.ready)) begin
      plan_item_t head;
      logic       go_req;
      logic       go_cfg;
      go_req = 1'b0;
      go_cfg = 1'b0;
      if (request_plan.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        head = request_plan[0];
        if (!head.is_cfg) begin
          go_req = 1'b1;
          req_ch.restart <= head.restart;
          void'(request_plan.pop_front());
        end else if (!req_ch.valid && pending_features.size() == 0) begin
          // hold register writes until every feature in flight has come out
          go_cfg = 1'b1;
          cfg_ch.index <= head.idx;
          cfg_ch.data  <= head.data;
          void'(request_plan.pop_front());
        end
      end
      req_ch.valid <= go_req;
      cfg_ch.valid <= go_cfg;
    end
  end

  // feature receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      feat_ch.ready <= 1'b0;
    end else if (long_stall) begin
      long_stall = 1'b0;
      stall_left = HOLD_OFF_LEN - 1;
      feat_ch.ready <= 1'b0;
    end else begin
      feat_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.index, cfg_ch.data);
      if (req_ch.valid && req_ch.ready) begin
        pending_features.insert(pending_features.size(), enumerate_next(req_ch.restart));
        requests_taken++;
      end
      if (feat_ch.valid && feat_ch.ready) begin
        if (pending_features.size() == 0) begin
          bad_results++;
          if (bad_results <= SHOWN_ERRORS)
            $display("unexpected feature: kind=%0d a=(%0d,%0d) exh=%0b",
                     feat_ch.feature_kind, feat_ch.start_x, feat_ch.start_y,
                     feat_ch.exhausted);
        end else begin
          check_feature(pending_features.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (feat_ch.valid && feat_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** haar_feature_enumerator: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.restart   = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_WINDOW_WIDTH;
    cfg_ch.data      = '0;
    feat_ch.ready    = 1'b0;
    planned_requests = 0;
    requests_taken   = 0;
    bad_results      = 0;
    quiet_cycles     = 0;
    long_stall       = 1'b0;
    send_idle_pct    = 29;
    recv_idle_pct    = 78;
    win_w            = WINDOW_RESET;
    win_h            = WINDOW_RESET;
    kind_on          = '{1'b1, 1'b1, 1'b1, 1'b1};
    cur_kind         = KIND_HORIZ_TWO;
    cur_rect         = '{0, 0, 0, 0};
    walking          = 1'b0;
    used_up          = 1'b0;
    build_directed();
    build_random();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (requests_taken >= planned_requests / 6);
    @(negedge clk_i) long_stall = 1'b1;
    wait (requests_taken >= planned_requests / 3);
    send_idle_pct = 78;
    recv_idle_pct = 29;
    wait (requests_taken >= 2 * planned_requests / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // back up the feature side while requests keep coming
    @(negedge clk_i) long_stall = 1'b1;

    @(negedge clk_i);
    while (request_plan.size() != 0 || req_ch.valid || cfg_ch.valid ||
           pending_features.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_results == 0)
      $display("** haar_feature_enumerator: PASSED **");
    else
      $display("** haar_feature_enumerator: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
src/hfe_pkg.sv
src/hfe_if.sv
src/hfe_cfg_regs.sv
src/hfe_step.sv
src/hfe_split.sv
src/haar_feature_enumerator.sv
src/hfe_checker.sv
verif/haar_feature_enumerator_tb.sv
